// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/bpho_pkg.sv =====
// ---------------------------------------------------------------------------
// Block PSNR overlay package
// Widths, constants and the threshold mantissa table of the PSNR search.
// ---------------------------------------------------------------------------
package bpho_pkg;

    localparam int SSE_W   = 29;
    localparam int MANT_W  = 27;
    localparam int PROD_W  = SSE_W + MANT_W;
    localparam int LHS_W   = 73;
    localparam int FRAC_W  = 24;
    localparam int LEVEL_W = 6;
    localparam int PIX_W   = 8;

    localparam logic [SSE_W-1:0]   SSE_MAX    = {SSE_W{1'b1}};
    localparam logic [15:0]        PEAK_SQ    = 16'd65025;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 6'd23;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN  = 6'd24;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 6'd52;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 6'd53;
    localparam logic [7:0]         CB_VALUE   = 8'h00;

    // First threshold is 24 dB, last is 53 dB, as decade and unit digits
    localparam logic [2:0] DEC_FIRST  = 3'd2;
    localparam logic [3:0] UNIT_FIRST = 4'd4;
    localparam logic [2:0] DEC_LAST   = 3'd5;
    localparam logic [3:0] UNIT_LAST  = 4'd3;
    localparam logic [3:0] UNIT_WRAP  = 4'd9;

    // Status of the level search toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } srch_stat_t;

    // round(10^(j/10) * 2^24)
    function automatic logic [MANT_W-1:0] mant_val(input logic [3:0] j);
        logic [MANT_W-1:0] m;
        case (j)
            4'd0:    m = 27'd16777216;
            4'd1:    m = 27'd21121264;
            4'd2:    m = 27'd26590095;
            4'd3:    m = 27'd33474947;
            4'd4:    m = 27'd42142461;
            4'd5:    m = 27'd53054215;
            4'd6:    m = 27'd66791300;
            4'd7:    m = 27'd84085265;
            4'd8:    m = 27'd105857077;
            4'd9:    m = 27'd133266164;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/bpho_accum.sv =====
// ---------------------------------------------------------------------------
// Block PSNR squared error accumulator
// Sums squared luma differences and counts pixels, clearing at block end.
// ---------------------------------------------------------------------------
module bpho_accum
    import bpho_pkg::*;
#(
    parameter int MAX_BLOCK_SIDE = 64,
    parameter int CNT_W = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [PIX_W-1:0] recon,
    input  logic [PIX_W-1:0] orig,
    input  logic             last,
    output logic [SSE_W-1:0] sum_next,
    output logic [CNT_W-1:0] cnt_next
);

    localparam int LIMIT = MAX_BLOCK_SIDE * MAX_BLOCK_SIDE;

    logic [SSE_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PIX_W-1:0] diff;
    logic [15:0]      sq;
    logic [SSE_W:0]   sum_wide;

    // Square the absolute difference and add with saturation
    always_comb
    begin
        diff     = (recon > orig) ? (recon - orig) : (orig - recon);
        sq       = {8'd0, diff} * {8'd0, diff};
        sum_wide = {1'b0, sum_reg} + (SSE_W+1)'(sq);
        sum_next = sum_wide[SSE_W] ? SSE_MAX : sum_wide[SSE_W-1:0];
        cnt_next = (cnt_reg < CNT_W'(LIMIT)) ? (cnt_reg + 1'b1) : cnt_reg;
    end

    // Advance on each request, clear after the last pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

// ===== sv/bpho_search.sv =====
// ---------------------------------------------------------------------------
// Block PSNR level search
// Walks thresholds 24..53 dB with one shared multiplier and a x10 scaler.
// ---------------------------------------------------------------------------
module bpho_search
    import bpho_pkg::*;
#(
    parameter int CNT_W = 13
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SSE_W-1:0]   sse_in,
    input  logic [CNT_W-1:0]   cnt_in,
    input  logic               take,
    output srch_stat_t         stat,
    output logic [LEVEL_W-1:0] level
);

    localparam int X_W = 16 + CNT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_XMUL  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [SSE_W-1:0]   sse_reg, sse_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [X_W-1:0]     x_reg, x_next;
    logic [LHS_W-1:0]   lhs_reg, lhs_next;
    logic [2:0]         dec_reg, dec_next;
    logic [3:0]         unit_reg, unit_next;
    logic [2:0]         dcnt_reg, dcnt_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    logic [SSE_W-1:0]   mul_a;
    logic [MANT_W-1:0]  mul_b;
    logic [PROD_W-1:0]  prod;
    logic [LHS_W-1:0]   lhs_x10;
    logic [LHS_W-1:0]   rhs;
    logic               pass;

    // Shared multiplier: peak times count, then error sum times mantissa
    always_comb
    begin
        if (state_reg == ST_XMUL)
        begin
            mul_a = SSE_W'(cnt_reg);
            mul_b = MANT_W'(PEAK_SQ);
        end
        else
        begin
            mul_a = sse_reg;
            mul_b = mant_val(unit_reg);
        end
        prod    = {{MANT_W{1'b0}}, mul_a} * {{SSE_W{1'b0}}, mul_b};
        lhs_x10 = (lhs_reg << 3) + (lhs_reg << 1);
        rhs     = {{(LHS_W-X_W-FRAC_W){1'b0}}, x_reg, {FRAC_W{1'b0}}};
        pass    = (lhs_reg <= rhs);
    end

    // Sequence the threshold walk
    always_comb
    begin
        state_next = state_reg;
        sse_next   = sse_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        lhs_next   = lhs_reg;
        dec_next   = dec_reg;
        unit_next  = unit_reg;
        dcnt_next  = dcnt_reg;
        level_next = level_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sse_next = sse_in;
                    cnt_next = cnt_in;
                    if (sse_in == '0)
                    begin
                        level_next = LEVEL_HIGH;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_XMUL;
                    end
                end
            end
            ST_XMUL:
            begin
                x_next     = prod[X_W-1:0];
                dec_next   = DEC_FIRST;
                unit_next  = UNIT_FIRST;
                level_next = LEVEL_LOW;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                lhs_next   = LHS_W'(prod);
                dcnt_next  = dec_reg;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                lhs_next  = lhs_x10;
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == 3'd1)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (pass)
                begin
                    level_next = level_reg + 1'b1;
                    if (dec_reg == DEC_LAST && unit_reg == UNIT_LAST)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (unit_reg == UNIT_WRAP)
                        begin
                            unit_next = '0;
                            dec_next  = dec_reg + 1'b1;
                        end
                        else
                        begin
                            unit_next = unit_reg + 1'b1;
                        end
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold datapath registers
    always_ff @(posedge clk)
    begin
        sse_reg   <= sse_next;
        cnt_reg   <= cnt_next;
        x_reg     <= x_next;
        lhs_reg   <= lhs_next;
        dec_reg   <= dec_next;
        unit_reg  <= unit_next;
        dcnt_reg  <= dcnt_next;
        level_reg <= level_next;
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);
    assign level     = level_reg;

endmodule

// ===== sv/block_psnr_heatmap_overlay_top.sv =====
// ---------------------------------------------------------------------------
// Block PSNR heat-map overlay top level
// Per-block luma PSNR level with cr and cb overlay values.
// ---------------------------------------------------------------------------
// Usage:
//   The slave stream carries one pixel pair per request: recon luma and
//   orig luma in s_tdata, s_tlast high on the last pixel of the block.
//   Pixels are taken one per cycle while s_tready is high.
//   After the last pixel, s_tready drops while the level search runs: zero
//   error goes straight to the result; otherwise the walk of the 30 thresholds
//   stops at the first that fails, with one multiply, two to five x10 steps
//   and one compare per threshold on the shared multiplier and scaler.
//   The master stream gives one request per block: level, cr and cb.
//   The result sits in an output register; pixels of the next block are
//   taken while it waits, but a finished search waits for that register
//   to free before the block accepts the next pixel.
//   When the receiver stalls, m_tdata holds until m_tready.
//   Reset clears the error sum, the pixel count, the sequencer and the
//   output valid; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module block_psnr_heatmap_overlay_top
    import bpho_pkg::*;
#(
    parameter int MAX_BLOCK_SIDE = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // recon_luma[7:0], orig_luma[15:8]
    input  logic        s_tlast,   // block_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // psnr_level[5:0], cr_overlay[13:6],
                                   // cb_overlay[21:14], zero[23:22]
);

    localparam int CNT_W = $clog2(MAX_BLOCK_SIDE * MAX_BLOCK_SIDE + 1);

    logic               s_take;
    logic [SSE_W-1:0]   sum_next;
    logic [CNT_W-1:0]   cnt_next;
    srch_stat_t         stat;
    logic [LEVEL_W-1:0] level;
    logic               load;
    logic [LEVEL_W-1:0] clipped;
    logic [4:0]         steps;
    logic [7:0]         cr_value;

    logic               m_valid_reg;
    logic [LEVEL_W-1:0] psnr_reg;
    logic [7:0]         cr_reg;

    assign s_tready = !stat.busy;
    assign s_take   = s_tvalid && s_tready;

    bpho_accum #(
        .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE),
        .CNT_W          (CNT_W)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (s_take),
        .recon    (s_tdata[7:0]),
        .orig     (s_tdata[15:8]),
        .last     (s_tlast),
        .sum_next (sum_next),
        .cnt_next (cnt_next)
    );

    bpho_search #(
        .CNT_W (CNT_W)
    ) u_search (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (s_take && s_tlast),
        .sse_in (sum_next),
        .cnt_in (cnt_next),
        .take   (load),
        .stat   (stat),
        .level  (level)
    );

    // Clamp the level and form cr = 9 * (52 - clipped)
    always_comb
    begin
        if (level < LEVEL_MIN)
        begin
            clipped = LEVEL_MIN;
        end
        else if (level > LEVEL_TOP)
        begin
            clipped = LEVEL_TOP;
        end
        else
        begin
            clipped = level;
        end
        steps    = 5'(LEVEL_TOP - clipped);
        cr_value = ({3'd0, steps} << 3) + {3'd0, steps};
    end

    assign load = stat.done && (!m_valid_reg || m_tready);

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            psnr_reg <= level;
            cr_reg   <= cr_value;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, CB_VALUE, cr_reg, psnr_reg};

    `ASSERT_NEXT(a_last_blocks_input, s_tvalid && s_tready && s_tlast, !s_tready,
        "pixel taken while level search should be running")
    `ASSERT_SAME(a_level_range, m_tvalid,
        m_tdata[5:0] >= LEVEL_LOW && m_tdata[5:0] <= LEVEL_HIGH,
        "psnr level out of range")
    `ASSERT_SAME(a_cr_range, m_tvalid, m_tdata[13:6] <= 8'd252 && m_tdata[21:14] == 8'd0,
        "overlay values out of range")

endmodule
